[src/ghi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghi_pkg
// Shared types and constants of the gyro heading integrator: register widths,
// register indexes, reset values and the Q3.28 angle limits.
// ----------------------------------------------------------------------------
package ghi_pkg;

   localparam int BIAS_W      = 20;
   localparam int THR_W       = 20;
   localparam int GAIN_W      = 24;
   localparam int RATE_OUT_W  = 21;
   localparam int HEAD_OUT_W  = 31;
   localparam int HEAD_W      = 32;
   localparam int STEP_SHIFT  = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int RSP_TDATA_W = ((RATE_OUT_W + HEAD_OUT_W + 7) / 8) * 8;

   localparam logic signed [HEAD_W-1:0] PI_Q28     = 32'sd843314857;
   localparam logic signed [HEAD_W-1:0] TWO_PI_Q28 = 32'sd1686629714;

   localparam logic [BIAS_W-1:0] BIAS_RESET     = 20'd0;
   localparam logic [THR_W-1:0]  DEADBAND_RESET = 20'd1201;
   localparam logic [GAIN_W-1:0] GAIN_RESET     = 24'd732700;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_BIAS  = 2'd0,
      CSR_DEADBAND   = 2'd1,
      CSR_ANGLE_GAIN = 2'd2
   } csr_index_type;

   // Register file contents as seen by the datapath.
   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [THR_W-1:0]  thr;
      logic [BIAS_W-1:0] bias;
   } cfg_type;

endpackage : ghi_pkg
`default_nettype wire

[src/ghi_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghi_window
// Sample ring with running window sum, bias removal and deadband. One item
// per cycle while out_ready allows it; the result is held in a register stage.
// ----------------------------------------------------------------------------
module ghi_window
   import ghi_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int SAMPLE_W = 16,
   parameter int SUM_W    = SAMPLE_W + $clog2(DEPTH),
   parameter int RATE_W   = ((SUM_W > BIAS_W) ? SUM_W : BIAS_W) + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  cfg_type                    cfg,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [RATE_W-1:0]   rate
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CMP_W  = RATE_W + 1;

   logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];
   logic signed [SAMPLE_W-1:0] old_rd_ff;
   logic                       old_valid_ff;
   logic [DEPTH-1:0]           filled_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [SLOT_W-1:0]          slot_in;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic signed [SUM_W-1:0]    old_ext;
   logic signed [BIAS_W-1:0]   bias_s;
   logic signed [RATE_W-1:0]   diff;
   logic signed [CMP_W-1:0]    diff_ext;
   logic signed [CMP_W-1:0]    thr_ext;
   logic signed [RATE_W-1:0]   rate_ff;
   logic                       valid_ff;
   logic                       fire;

   assign in_ready  = !valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign rate      = rate_ff;

   assign slot_in = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);

   // Entry leaving the window; never-written entries count as zero.
   assign old_ext  = old_valid_ff ? SUM_W'(old_rd_ff) : '0;
   assign sum_in   = sum_ff - old_ext + SUM_W'(sample);
   assign bias_s   = $signed(cfg.bias);
   assign diff     = RATE_W'(sum_in) - RATE_W'(bias_s);
   assign diff_ext = CMP_W'(diff);
   assign thr_ext  = $signed(CMP_W'(cfg.thr));

   // Write the current slot and prefetch the next one; the two differ.
   always_ff @(posedge clock) begin
      if (fire) begin
         ring_mem[slot_ff] <= sample;
         old_rd_ff         <= ring_mem[slot_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         old_valid_ff <= 1'b0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (fire) begin
            filled_ff[slot_ff] <= 1'b1;
            old_valid_ff       <= filled_ff[slot_in];
            slot_ff            <= slot_in;
            sum_ff             <= sum_in;
            valid_ff           <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if ((diff_ext > -thr_ext) && (diff_ext < thr_ext)) begin
            rate_ff <= '0;
         end else begin
            rate_ff <= diff;
         end
      end
   end

endmodule : ghi_window
`default_nettype wire

[src/ghi_integrator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghi_integrator
// Scales the corrected rate by the gain into a heading step, then
// accumulates and wraps the heading into [-pi, pi]. Two register stages.
// ----------------------------------------------------------------------------
module ghi_integrator
   import ghi_pkg::*;
#(
   parameter int RATE_W = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [RATE_W-1:0]     rate,
   input  logic [GAIN_W-1:0]            gain,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [RATE_OUT_W-1:0] corrected_rate,
   output logic signed [HEAD_OUT_W-1:0] heading
);

   localparam int PROD_W = RATE_W + GAIN_W + 1;
   localparam int STEP_W = PROD_W - STEP_SHIFT;
   localparam int ACC_W  = ((STEP_W > HEAD_W) ? STEP_W : HEAD_W) + 1;
   localparam int EXT_W  = (RATE_W > RATE_OUT_W) ? RATE_W : RATE_OUT_W;

   logic signed [PROD_W-1:0]     prod;
   logic signed [STEP_W-1:0]     step_ff;
   logic signed [RATE_W-1:0]     p_rate_ff;
   logic                         p_valid_ff;
   logic                         p_ready;
   logic                         p_fire;
   logic signed [ACC_W-1:0]      acc;
   logic signed [ACC_W-1:0]      acc_wrap;
   logic signed [HEAD_W-1:0]     heading_ff;
   logic signed [HEAD_W-1:0]     heading_in;
   logic signed [EXT_W-1:0]      rate_ext;
   logic signed [RATE_OUT_W-1:0] rate_out_ff;
   logic signed [HEAD_OUT_W-1:0] head_out_ff;
   logic                         o_valid_ff;
   logic                         o_ready;
   logic                         o_fire;

   assign o_ready  = !o_valid_ff || out_ready;
   assign p_ready  = !p_valid_ff || o_ready;
   assign in_ready = p_ready;
   assign p_fire   = in_valid && p_ready;
   assign o_fire   = p_valid_ff && o_ready;

   // Upper bits of the product are the step floored by 2^16.
   assign prod = $signed(rate) * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      if (p_fire) begin
         step_ff   <= $signed(prod[PROD_W-1:STEP_SHIFT]);
         p_rate_ff <= rate;
      end
   end

   // Wrap once; a single step is always below two pi.
   assign acc = ACC_W'(heading_ff) + ACC_W'(step_ff);
   always_comb begin
      if (acc > ACC_W'(PI_Q28)) begin
         acc_wrap = acc - ACC_W'(TWO_PI_Q28);
      end else if (acc < -ACC_W'(PI_Q28)) begin
         acc_wrap = acc + ACC_W'(TWO_PI_Q28);
      end else begin
         acc_wrap = acc;
      end
   end
   assign heading_in = acc_wrap[HEAD_W-1:0];
   assign rate_ext   = EXT_W'(p_rate_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         heading_ff <= '0;
      end else begin
         if (p_fire) begin
            p_valid_ff <= 1'b1;
         end else if (o_ready) begin
            p_valid_ff <= 1'b0;
         end
         if (o_fire) begin
            o_valid_ff <= 1'b1;
            heading_ff <= heading_in;
         end else if (out_ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (o_fire) begin
         rate_out_ff <= rate_ext[RATE_OUT_W-1:0];
         head_out_ff <= heading_in[HEAD_OUT_W-1:0];
      end
   end

   assign out_valid      = o_valid_ff;
   assign corrected_rate = rate_out_ff;
   assign heading        = head_out_ff;

endmodule : ghi_integrator
`default_nettype wire

[src/gyro_heading_integrator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_heading_integrator
// Yaw-rate stream to heading: window-sum average, bias, deadband, gain and
// wrapped Q3.28 heading accumulation.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, window stage, step stage
// and heading/result stage in that order before rsp_tvalid rises.
// Throughput: one item per cycle while rsp_tready is high; the window-sum and
// heading accumulator each close their loop through a single register, and every
// stage advances as soon as the one after it is free.
// Reset: synchronous, clears the sample history, window sum, heading, all
// pipeline valids, and loads the register defaults (bias 0, deadband 1201,
// gain 732700).
// ----------------------------------------------------------------------------
module gyro_heading_integrator
   import ghi_pkg::*;
#(
   parameter int HISTORY_DEPTH = 16,
   parameter int SAMPLE_WIDTH  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Input items
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // rate_sample
   // Result items
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]                  rsp_tdata,  // corrected_rate, heading
   // Register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [CSR_IDX_W-1:0]                    csr_index,
   input  logic [CSR_DATA_W-1:0]                   csr_data
);

   localparam int SUM_W  = SAMPLE_WIDTH + $clog2(HISTORY_DEPTH);
   localparam int RATE_W = ((SUM_W > BIAS_W) ? SUM_W : BIAS_W) + 1;
   localparam int PAD_W  = RSP_TDATA_W - RATE_OUT_W - HEAD_OUT_W;

   cfg_type                        cfg_ff;
   logic                           s0_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] s0_sample_ff;
   logic                           win_ready;
   logic                           win_valid;
   logic signed [RATE_W-1:0]       win_rate;
   logic                           int_ready;
   logic signed [RATE_OUT_W-1:0]   corrected_rate;
   logic signed [HEAD_OUT_W-1:0]   heading;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bias <= BIAS_RESET;
         cfg_ff.thr  <= DEADBAND_RESET;
         cfg_ff.gain <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_RATE_BIAS:  cfg_ff.bias <= csr_data[BIAS_W-1:0];
            CSR_DEADBAND:   cfg_ff.thr  <= csr_data[THR_W-1:0];
            CSR_ANGLE_GAIN: cfg_ff.gain <= csr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: hold the item until the window stage takes it.
   assign req_tready = !s0_valid_ff || win_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s0_valid_ff <= 1'b1;
      end else if (win_ready) begin
         s0_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s0_sample_ff <= $signed(req_tdata[SAMPLE_WIDTH-1:0]);
      end
   end

   // Window sum, bias and deadband.
   ghi_window #(
      .DEPTH    (HISTORY_DEPTH),
      .SAMPLE_W (SAMPLE_WIDTH),
      .SUM_W    (SUM_W),
      .RATE_W   (RATE_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (win_ready),
      .sample    (s0_sample_ff),
      .cfg       (cfg_ff),
      .out_valid (win_valid),
      .out_ready (int_ready),
      .rate      (win_rate)
   );

   // Gain, heading accumulation and the result register.
   ghi_integrator #(
      .RATE_W (RATE_W)
   ) u_integrator (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (win_valid),
      .in_ready       (int_ready),
      .rate           (win_rate),
      .gain           (cfg_ff.gain),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .corrected_rate (corrected_rate),
      .heading        (heading)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, heading, corrected_rate};

endmodule : gyro_heading_integrator
`default_nettype wire
